[rtl/min_tracking_stack_unit_macros.svh]
// assertion macros for the min tracking stack checker
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef MIN_TRACKING_STACK_UNIT_MACROS_SVH
`define MIN_TRACKING_STACK_UNIT_MACROS_SVH

// same-cycle implication
`define MTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/mts_pkg.sv]
// shared types and constants for the min tracking stack
// no dependencies
package mts_pkg;

  // operation kind
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // fault codes reported with each result
  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_POP_EMPTY = 2'd1,
    FAULT_PUSH_FULL = 2'd2
  } fault_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_op;  // latch the operation and start the ram read
    logic commit;   // apply the operation and load the result register
  } mts_cmd_t;

endpackage

[rtl/mts_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module mts_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mts_ctrl.sv]
// controller for the min tracking stack: handshakes and sequencing
// depends on mts_pkg
module mts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mts_pkg::mts_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic commit;

  // one transaction in flight at a time
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // commit once the result register is free or being emptied
  assign commit     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.load_op = accept;
  assign cmd_o.commit  = commit;

endmodule

[rtl/mts_dpath.sv]
// datapath for the min tracking stack: count, minimum, cached top, result register
// depends on mts_pkg and mts_ram
module mts_dpath #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mts_pkg::mts_cmd_t            cmd_i,
  input  logic                         kind_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic signed [DATA_WIDTH-1:0] popped_value_o,
  output logic                         popped_valid_o,
  output logic signed [DATA_WIDTH-1:0] top_value_o,
  output logic signed [DATA_WIDTH-1:0] min_value_o,
  output logic                         is_empty_o,
  output logic [1:0]                   fault_o
);

  localparam int SW = DATA_WIDTH + 2;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [DATA_WIDTH-1:0] WordMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);
  localparam logic [CW-1:0] CntOne  = CW'(1);
  localparam logic [CW-1:0] CntTwo  = CW'(2);

  // state
  logic [CW-1:0]                cnt_q, cnt_d;
  logic signed [DATA_WIDTH-1:0] min_q, min_d;
  logic signed [SW-1:0]         top_q, top_d;
  logic                         kind_q;
  logic signed [DATA_WIDTH-1:0] val_q;

  // result register
  logic signed [DATA_WIDTH-1:0] res_popped_q, res_popped_d;
  logic                         res_pvalid_q, res_pvalid_d;
  logic signed [DATA_WIDTH-1:0] res_top_q, res_top_d;
  logic                         res_empty_q, res_empty_d;
  mts_pkg::fault_e              res_fault_q, res_fault_d;

  // ram signals
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [SW-1:0]     ram_rdata;
  logic signed [SW-1:0] below_s;

  logic signed [SW-1:0] val_ext, min_ext, push_word, marker;
  logic [SW-1:0]        recover;

  // latch the operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      kind_q <= kind_i;
      val_q  <= value_i;
    end
  end

  // read the entry under the top while the operation is latched
  assign ram_raddr = AW'(cnt_q - CntTwo);
  assign ram_we    = cmd_i.commit && (kind_q == mts_pkg::KIND_PUSH) && (cnt_q != CntFull);
  assign below_s   = ram_rdata;

  mts_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (push_word),
    .re_i    (cmd_i.load_op),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // encode a push: marker 2v - min when v drops below the minimum
  assign val_ext = SW'(val_q);
  assign min_ext = SW'(min_q);
  assign marker  = {val_q[DATA_WIDTH-1], val_q, 1'b0} - min_ext;
  assign push_word = (val_ext < min_ext) ? marker : val_ext;
  // recover the previous minimum from a popped marker
  assign recover = {min_q[DATA_WIDTH-1], min_q, 1'b0} - top_q;

  // apply the operation
  always_comb begin
    cnt_d        = cnt_q;
    min_d        = min_q;
    top_d        = top_q;
    res_popped_d = '0;
    res_pvalid_d = 1'b0;
    res_fault_d  = mts_pkg::FAULT_NONE;
    res_top_d    = '1;
    if (kind_q == mts_pkg::KIND_PUSH) begin
      if (cnt_q == CntFull) begin
        res_fault_d = mts_pkg::FAULT_PUSH_FULL;
      end else begin
        cnt_d = cnt_q + CntOne;
        top_d = push_word;
        if (val_ext < min_ext) begin
          min_d = val_q;
        end
      end
    end else begin
      if (cnt_q == '0) begin
        res_fault_d = mts_pkg::FAULT_POP_EMPTY;
      end else begin
        cnt_d        = cnt_q - CntOne;
        res_pvalid_d = 1'b1;
        top_d        = below_s;
        if (top_q < min_ext) begin
          res_popped_d = min_q;
          min_d        = recover[DATA_WIDTH-1:0];
        end else begin
          res_popped_d = top_q[DATA_WIDTH-1:0];
        end
      end
    end
    // decoded top after the step
    if (cnt_d != '0) begin
      res_top_d = (top_d < SW'(min_d)) ? min_d : top_d[DATA_WIDTH-1:0];
    end
    res_empty_d = (cnt_d == '0);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      min_q <= WordMax;
    end else if (cmd_i.commit) begin
      cnt_q <= cnt_d;
      min_q <= min_d;
    end
  end

  // cached top and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      top_q        <= top_d;
      res_popped_q <= res_popped_d;
      res_pvalid_q <= res_pvalid_d;
      res_top_q    <= res_top_d;
      res_empty_q  <= res_empty_d;
      res_fault_q  <= res_fault_d;
    end
  end

  assign popped_value_o = res_popped_q;
  assign popped_valid_o = res_pvalid_q;
  assign top_value_o    = res_top_q;
  assign min_value_o    = min_q;
  assign is_empty_o     = res_empty_q;
  assign fault_o        = res_fault_q;

endmodule

[rtl/min_tracking_stack_unit.sv]
// top level of the min tracking stack: controller plus datapath
// depends on mts_pkg, mts_ctrl, mts_dpath, mts_ram
//
//  channel | handshake               | payload
//  in      | in_valid_i / in_ready_o | kind_i, value_i
//  out     | out_valid_o/out_ready_i | popped_value_o, popped_valid_o, top_value_o,
//          |                         | min_value_o, is_empty_o, fault_o
//
// each transaction is accepted, then committed once the ram read of the
// entry under the top has landed from the registered ram read port
// one input transaction at a time; in_ready_o drops while one waits to commit
// a stalled output holds its result; the next transaction is still accepted but cannot
// commit, so the input stalls too until the held result is taken
// reset empties the stack and sets the minimum to the largest positive value
module min_tracking_stack_unit #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] popped_value_o,
  output logic                         popped_valid_o,
  output logic signed [DATA_WIDTH-1:0] top_value_o,
  output logic signed [DATA_WIDTH-1:0] min_value_o,
  output logic                         is_empty_o,
  output logic [1:0]                   fault_o
);

  mts_pkg::mts_cmd_t cmd;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mts_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .popped_value_o (popped_value_o),
    .popped_valid_o (popped_valid_o),
    .top_value_o    (top_value_o),
    .min_value_o    (min_value_o),
    .is_empty_o     (is_empty_o),
    .fault_o        (fault_o)
  );

endmodule

[rtl/mts_checker.sv]
// port-level checks for the min tracking stack, bound to the top level
// depends on mts_pkg and min_tracking_stack_unit_macros.svh
`include "min_tracking_stack_unit_macros.svh"

module mts_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] popped_value_o,
  input logic                         popped_valid_o,
  input logic signed [DATA_WIDTH-1:0] top_value_o,
  input logic                         is_empty_o,
  input logic [1:0]                   fault_o
);

  // a held result stays offered
  `MTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // one transaction in flight: no accept in the cycle after an accept
  `MTS_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // an empty stack reports a top of minus one
  `MTS_ASSERT_SAME(a_empty_top, out_valid_o && is_empty_o, top_value_o == '1)

  // a faulted transaction removes nothing and reports a zero pop value
  `MTS_ASSERT_SAME(a_fault_no_pop, out_valid_o && (fault_o != mts_pkg::FAULT_NONE),
    !popped_valid_o && (popped_value_o == '0))

endmodule

bind min_tracking_stack_unit mts_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mts_checker (.*);

[test/stack_result_checker.sv]
// result checker for the min tracking stack: keeps a shadow stack and compares every result
// depends on mts_pkg; instantiated by tb beside the block
`timescale 1ns / 100ps

module stack_result_checker
  import mts_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         kind_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [DATA_WIDTH-1:0] popped_value_i,
  input  logic                         popped_valid_i,
  input  logic signed [DATA_WIDTH-1:0] top_value_i,
  input  logic signed [DATA_WIDTH-1:0] min_value_i,
  input  logic                         is_empty_i,
  input  logic [1:0]                   fault_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // what the block should report after one operation
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] popped_value;
    logic                         popped_valid;
    logic signed [DATA_WIDTH-1:0] top_value;
    logic signed [DATA_WIDTH-1:0] min_value;
    logic                         is_empty;
    fault_e                       fault;
  } stack_view_t;

  // shadow stack: words two bits wider than the data so a marker always fits
  logic signed [DATA_WIDTH+1:0] shadow_mem [DEPTH];
  int unsigned                  shadow_fill;
  logic signed [DATA_WIDTH-1:0] shadow_min;
  stack_view_t                  expected_views [$];
  stack_view_t                  want;

  // apply one operation to the shadow stack and return the view it should leave
  function automatic stack_view_t step_shadow_stack(logic kind, logic signed [DATA_WIDTH-1:0] val);
    stack_view_t                  r;
    logic signed [DATA_WIDTH+1:0] wide_val;
    logic signed [DATA_WIDTH+1:0] wide_min;
    logic signed [DATA_WIDTH+1:0] word;
    r        = '0;
    r.fault  = FAULT_NONE;
    wide_val = val;
    wide_min = shadow_min;
    if (kind == KIND_PUSH) begin
      if (shadow_fill >= DEPTH) begin
        r.fault = FAULT_PUSH_FULL;
      end else begin
        // a new minimum is stored as a marker below it
        if (wide_val < wide_min) begin
          shadow_mem[shadow_fill] = (wide_val <<< 1) - wide_min;
          shadow_min              = val;
        end else begin
          shadow_mem[shadow_fill] = wide_val;
        end
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      r.fault = FAULT_POP_EMPTY;
    end else begin
      word = shadow_mem[shadow_fill-1];
      // popping a marker gives back the minimum and recovers the one before it
      if (word < wide_min) begin
        r.popped_value = shadow_min;
        wide_min       = (wide_min <<< 1) - word;
        shadow_min     = wide_min[DATA_WIDTH-1:0];
      end else begin
        r.popped_value = word[DATA_WIDTH-1:0];
      end
      r.popped_valid = 1'b1;
      shadow_fill--;
    end

    // decoded top after the operation
    wide_min    = shadow_min;
    r.min_value = shadow_min;
    if (shadow_fill == 0) begin
      r.top_value = '1;
      r.is_empty  = 1'b1;
    end else begin
      word        = shadow_mem[shadow_fill-1];
      r.top_value = (word < wide_min) ? shadow_min : word[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic void check_field(string field, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      fail_count_o++;
    end
  endfunction

  // results are compared before the same-cycle input is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      shadow_min  = WORD_MAX;
      expected_views.delete();
      pending_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_views.size() == 0) begin
          $error("result transaction with no operation outstanding");
          fail_count_o++;
        end else begin
          want = expected_views.pop_front();
          check_field("popped_value", want.popped_value, popped_value_i);
          check_field("popped_valid", want.popped_valid, popped_valid_i);
          check_field("top_value", want.top_value, top_value_i);
          check_field("min_value", want.min_value, min_value_i);
          check_field("is_empty", want.is_empty, is_empty_i);
          check_field("fault", want.fault, fault_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_views.push_back(step_shadow_stack(kind_i, value_i));
      end
      pending_o = expected_views.size();
    end
  end

endmodule

[test/tb.sv]
// testbench top for the min tracking stack: clock, reset, stimulus and verdict
// depends on mts_pkg, min_tracking_stack_unit and stack_result_checker
`timescale 1ns / 100ps

module tb;
  import mts_pkg::*;

  localparam int DEPTH       = 256;
  localparam int DW          = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  localparam logic signed [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum int {
    VAL_RANDOM,
    VAL_SMALL,
    VAL_EXTREME,
    VAL_FALLING,
    VAL_NEAR_EDGE
  } value_style_e;

  typedef enum int {
    BURST_GROW,
    BURST_SHRINK,
    BURST_MIXED
  } burst_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 kind_i;
  logic signed [DW-1:0] value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [DW-1:0] popped_value_o;
  logic                 popped_valid_o;
  logic signed [DW-1:0] top_value_o;
  logic signed [DW-1:0] min_value_o;
  logic                 is_empty_o;
  logic [1:0]           fault_o;

  int                   fail_count;
  int                   pending;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   hold_off_len;
  int                   quiet_cycles;
  logic signed [DW-1:0] last_pushed;

  min_tracking_stack_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .popped_valid_o (popped_valid_o),
    .top_value_o    (top_value_o),
    .min_value_o    (min_value_o),
    .is_empty_o     (is_empty_o),
    .fault_o        (fault_o)
  );

  stack_result_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_i (popped_value_o),
    .popped_valid_i (popped_valid_o),
    .top_value_i    (top_value_o),
    .min_value_i    (min_value_o),
    .is_empty_i     (is_empty_o),
    .fault_i        (fault_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_len > 0) begin
        stall_left   = hold_off_len;
        hold_off_len = 0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic signed [DW-1:0] pick_value(value_style_e style,
                                                      logic signed [DW-1:0] prev);
    case (style)
      VAL_SMALL:   return $signed($urandom_range(16)) - 8;
      VAL_EXTREME: begin
        case ($urandom_range(3))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      VAL_FALLING: return prev - $urandom_range(3);
      VAL_NEAR_EDGE: begin
        if ($urandom_range(1) != 0) return WORD_MIN + $urandom_range(15);
        return WORD_MAX - $urandom_range(15);
      end
      default:     return $urandom;
    endcase
  endfunction

  // one operation, with random idle cycles ahead of it
  task automatic send_op(input logic kind, input logic signed [DW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic push_value(input logic signed [DW-1:0] val);
    send_op(KIND_PUSH, val);
  endtask

  task automatic pop_top();
    send_op(KIND_POP, $urandom);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // bursts that lean towards growing, shrinking or holding the depth
  task automatic run_bursts(input int n_items);
    int                   sent;
    int                   len;
    int                   push_pct;
    burst_e               mode;
    value_style_e         style;
    logic signed [DW-1:0] v;
    sent = 0;
    while (sent < n_items) begin
      mode     = burst_e'($urandom_range(2));
      style    = value_style_e'($urandom_range(4));
      len      = $urandom_range(48, 8);
      push_pct = (mode == BURST_GROW) ? 80 : (mode == BURST_SHRINK) ? 25 : 55;
      repeat (len) begin
        if ($urandom_range(99) < push_pct) begin
          v           = pick_value(style, last_pushed);
          last_pushed = v;
          push_value(v);
        end else begin
          pop_top();
        end
        sent++;
      end
    end
  endtask

  // fill past the top so pushes get dropped, then empty past the bottom
  task automatic fill_and_empty();
    logic signed [DW-1:0] v;
    repeat (DEPTH + 4) begin
      v           = pick_value(value_style_e'($urandom_range(4)), last_pushed);
      last_pushed = v;
      push_value(v);
    end
    repeat (DEPTH + 4) pop_top();
  endtask

  // stimulus and verdict
  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_PUSH;
    value_i       <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_len  = 0;
    last_pushed   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, extreme markers, equal pushes, unwind to empty
    pop_top();
    push_value(WORD_MIN);
    push_value(WORD_MIN);
    push_value(WORD_MAX);
    push_value(-1);
    repeat (4) pop_top();
    pop_top();
    push_value(WORD_MAX);
    push_value(0);
    push_value(32'sh5555_5555);
    push_value(32'shAAAA_AAAA);
    push_value(1);
    push_value(WORD_MIN + 1);
    push_value(WORD_MIN + 1);
    repeat (7) pop_top();
    pop_top();
    wait_drained();

    // slow receiver
    send_idle_pct = 11;
    recv_idle_pct = 74;
    run_bursts(560);
    wait_drained();

    // slow sender
    send_idle_pct = 74;
    recv_idle_pct = 11;
    run_bursts(560);
    wait_drained();

    // full rate, with a long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_len  = HOLD_CYCLES;
    fill_and_empty();
    run_bursts(100);
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
